// ----- src/lcs_pkg.sv -----
`timescale 1ns / 1ps

package lcs_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int LEN_W       = 7;
    localparam int SYM_W       = 8;
    localparam int OP_W        = 2;

    // operation codes carried on s_tuser
    localparam logic [OP_W-1:0] OP_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_CALC   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_START = 3'd1,
        S_ROW   = 3'd2,
        S_PRIME = 3'd3,
        S_CELL  = 3'd4,
        S_NEXT  = 3'd5,
        S_EMIT  = 3'd6,
        S_RET   = 3'd7
    } step_t;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NOT_CALC = 3'd2,
        C_EMPTY    = 3'd3,
        C_COL_MORE = 3'd4,
        C_ROW_MORE = 3'd5,
        C_OUT_BUSY = 3'd6
    } cond_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_ROW   = 3'd2,
        ACT_PRIME = 3'd3,
        ACT_CELL  = 3'd4,
        ACT_NEXT  = 3'd5,
        ACT_EMIT  = 3'd6
    } act_t;

    typedef struct packed {
        logic  take;
        cond_t cond;
        step_t target;
        act_t  act;
    } ctrl_t;

    typedef struct packed {
        logic calc_acc;
        logic empty;
        logic col_more;
        logic row_more;
        logic out_busy;
    } stat_t;

    // microprogram: a true condition jumps to target, otherwise advance one step
    function automatic ctrl_t ucode_rom(input step_t s);
        ctrl_t w;
        unique case (s)
            S_IDLE:  w = '{1'b1, C_NOT_CALC, S_IDLE,  ACT_NONE};
            S_START: w = '{1'b0, C_EMPTY,    S_EMIT,  ACT_START};
            S_ROW:   w = '{1'b0, C_NEXT,     S_IDLE,  ACT_ROW};
            S_PRIME: w = '{1'b0, C_NEXT,     S_IDLE,  ACT_PRIME};
            S_CELL:  w = '{1'b0, C_COL_MORE, S_CELL,  ACT_CELL};
            S_NEXT:  w = '{1'b0, C_ROW_MORE, S_ROW,   ACT_NEXT};
            S_EMIT:  w = '{1'b0, C_OUT_BUSY, S_EMIT,  ACT_EMIT};
            S_RET:   w = '{1'b0, C_ALWAYS,   S_IDLE,  ACT_NONE};
        endcase
        return w;
    endfunction

endpackage

// ----- src/lcs_ram.sv -----
`timescale 1ns / 1ps

module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/lcs_seq.sv -----
`timescale 1ns / 1ps

module lcs_seq (
    input  logic          aclk,
    input  logic          aresetn,
    input  lcs_pkg::stat_t stat,
    output lcs_pkg::ctrl_t ctrl
);
    import lcs_pkg::*;

    step_t step_reg, step_next;
    logic  jump;

    assign ctrl = ucode_rom(step_reg);

    always_comb begin
        unique case (ctrl.cond)
            C_NEXT:     jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NOT_CALC: jump = !stat.calc_acc;
            C_EMPTY:    jump = stat.empty;
            C_COL_MORE: jump = stat.col_more;
            C_ROW_MORE: jump = stat.row_more;
            C_OUT_BUSY: jump = stat.out_busy;
            default:    jump = 1'b0;
        endcase
        step_next = jump ? ctrl.target : step_t'(step_reg + 3'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- src/lcs_dp.sv -----
`timescale 1ns / 1ps

module lcs_dp #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lcs_pkg::ctrl_t              ctrl,
    output lcs_pkg::stat_t              stat,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lcs_pkg::SYM_W-1:0]   s_tdata,
    input  logic [lcs_pkg::OP_W-1:0]    s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic [0:0]                  m_tuser
);
    import lcs_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN > 1 ? MAX_LEN : 2);

    logic [CW-1:0]    first_cnt_reg, first_cnt_next;
    logic [CW-1:0]    second_cnt_reg, second_cnt_next;
    logic             dropped_reg, dropped_next;
    logic [AW-1:0]    i_reg, i_next;
    logic [AW-1:0]    col_reg, col_next;
    logic [CW-1:0]    diag_reg, diag_next;
    logic [CW-1:0]    left_reg, left_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             top_row_reg, top_row_next;
    logic             out_valid_reg, out_valid_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             accept;
    logic             first_we, second_we, score_we;
    logic [SYM_W-1:0] first_rdata, second_rdata;
    logic [CW-1:0]    score_rdata;
    logic [AW-1:0]    rd_col;
    logic [CW-1:0]    above, diag_hit, side, best;
    logic             emit;

    assign s_tready = ctrl.take;
    assign accept   = s_tvalid & ctrl.take;

    assign first_we  = accept && (s_tuser == OP_FIRST)  && (first_cnt_reg  != CW'(MAX_LEN));
    assign second_we = accept && (s_tuser == OP_SECOND) && (second_cnt_reg != CW'(MAX_LEN));

    // fetch the next column while the current cell is resolved
    assign rd_col   = (ctrl.act == ACT_CELL) ? col_reg + AW'(1) : col_reg;
    assign above    = top_row_reg ? '0 : score_rdata;
    assign diag_hit = diag_reg + CW'(sym_reg == second_rdata);
    assign side     = (left_reg > above) ? left_reg : above;
    assign best     = (diag_hit > side) ? diag_hit : side;
    assign score_we = (ctrl.act == ACT_CELL);

    assign stat.calc_acc = accept && (s_tuser == OP_CALC);
    assign stat.empty    = (first_cnt_reg == '0) || (second_cnt_reg == '0);
    assign stat.col_more = (CW'(col_reg) + CW'(1)) != second_cnt_reg;
    assign stat.row_more = (CW'(i_reg) + CW'(1)) != first_cnt_reg;
    assign stat.out_busy = out_valid_reg & ~m_tready;

    assign emit = (ctrl.act == ACT_EMIT) && !stat.out_busy;

    lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_first (
        .aclk  (aclk),
        .we    (first_we),
        .waddr (first_cnt_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (i_reg),
        .rdata (first_rdata)
    );

    lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_second (
        .aclk  (aclk),
        .we    (second_we),
        .waddr (second_cnt_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (rd_col),
        .rdata (second_rdata)
    );

    lcs_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_score (
        .aclk  (aclk),
        .we    (score_we),
        .waddr (col_reg),
        .wdata (best),
        .raddr (rd_col),
        .rdata (score_rdata)
    );

    always_comb begin
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        dropped_next    = dropped_reg;
        i_next          = i_reg;
        col_next        = col_reg;
        diag_next       = diag_reg;
        left_next       = left_reg;
        sym_next        = sym_reg;
        top_row_next    = top_row_reg;
        out_len_next    = out_len_reg;
        out_ovf_next    = out_ovf_reg;

        if (first_we) begin
            first_cnt_next = first_cnt_reg + CW'(1);
        end
        if (second_we) begin
            second_cnt_next = second_cnt_reg + CW'(1);
        end
        // flag an append to a full string
        if (accept && (((s_tuser == OP_FIRST) && !first_we) ||
                       ((s_tuser == OP_SECOND) && !second_we))) begin
            dropped_next = 1'b1;
        end

        unique case (ctrl.act)
            ACT_NONE: begin
            end
            ACT_START: begin
                i_next       = '0;
                left_next    = '0;
                top_row_next = 1'b1;
            end
            ACT_ROW: begin
                col_next  = '0;
                diag_next = '0;
                left_next = '0;
            end
            ACT_PRIME: begin
                sym_next = first_rdata;
            end
            ACT_CELL: begin
                left_next = best;
                diag_next = above;
                col_next  = col_reg + AW'(1);
            end
            ACT_NEXT: begin
                i_next       = i_reg + AW'(1);
                top_row_next = 1'b0;
            end
            ACT_EMIT: begin
                if (emit) begin
                    out_len_next    = LEN_W'(left_reg);
                    out_ovf_next    = dropped_reg;
                    first_cnt_next  = '0;
                    second_cnt_next = '0;
                    dropped_next    = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            dropped_reg    <= dropped_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        col_reg     <= col_next;
        diag_reg    <= diag_next;
        left_reg    <= left_next;
        sym_reg     <= sym_next;
        top_row_reg <= top_row_next;
        out_len_reg <= out_len_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - LEN_W){1'b0}}, out_len_reg};
    assign m_tuser  = out_ovf_reg;

endmodule

// ----- src/lcs_length_engine.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Ports                        Contents
// s_        in   s_tvalid s_tready s_tdata    tdata[7:0] symbol
//                s_tuser                      tuser[1:0] operation
// m_        out  m_tvalid m_tready m_tdata    tdata[6:0] lcs_length, tdata[7] zero
//                m_tuser                      tuser[0] overflow
//
// Appends are accepted back to back; s_tready stays high between computes.
// A compute holds s_tready low until it returns to idle; with both strings
// non-empty it resolves one DP cell per cycle through the score-row RAM,
// plus three steps per row, two of them to fetch its first-string character.
// Reset (aresetn low at a clock edge) empties both strings and clears the flag.
// A result not yet taken holds the next compute at its emit step.

module lcs_length_engine #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] symbol
    input  logic [lcs_pkg::OP_W-1:0]  s_tuser,   // [1:0] operation
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // [6:0] lcs_length, [7] zero
    output logic [0:0]                m_tuser    // [0] overflow
);
    import lcs_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    lcs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    lcs_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- src/lcs_chk.sv -----
`timescale 1ns / 1ps

module lcs_chk #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [lcs_pkg::OP_W-1:0] s_tuser,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [7:0]               m_tdata,
    input logic [0:0]               m_tuser
);
    import lcs_pkg::*;

    // a compute item blocks the input side in the next cycle
    a_calc_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_CALC)) |=> !s_tready)
        else $error("input still ready after compute item");

    // a new result appears only at the end of a compute
    a_result_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready)
        else $error("result appeared outside a compute");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((MAX_LEN > 127) || (m_tdata[6:0] <= MAX_LEN)))
        else $error("lcs length beyond string capacity");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind lcs_length_engine lcs_chk #(.MAX_LEN(MAX_LEN)) u_lcs_chk (.*);
